[rtl/m3i_pkg.sv]
package m3i_pkg;
    localparam int ELEM_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 24;
    localparam int ELEM_W = 16;
    localparam int Q_W    = 57;
    localparam int DET_W  = 49;
    localparam int ADJ_W  = 33;
    localparam int NUM_W  = ADJ_W + 24;
    localparam int DIV_W  = 56;
    localparam int LANES  = 9;
    localparam int PROD_W = 34;
endpackage

[rtl/m3i_if.sv]
interface m3i_in_if;
    import m3i_pkg::*;
    logic valid;
    logic ready;
    logic signed [ELEM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22, input ready);
    modport sink   (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22, output ready);
endinterface

interface m3i_out_if;
    import m3i_pkg::*;
    logic valid;
    logic ready;
    logic signed [Q_W-1:0] q00, q01, q02, q10, q11, q12, q20, q21, q22;
    logic signed [DET_W-1:0] determinant;
    logic invertible;
    modport source (output valid, q00, q01, q02, q10, q11, q12, q20, q21, q22,
                    determinant, invertible, input ready);
    modport sink   (input valid, q00, q01, q02, q10, q11, q12, q20, q21, q22,
                    determinant, invertible, output ready);
endinterface

[rtl/m3i_div_lane.sv]
// Pipelined restoring divider: one quotient bit per stage, magnitudes only.
module m3i_div_lane (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [m3i_pkg::DIV_W-1:0]       i_num,
    input  logic [m3i_pkg::DIV_W-1:0]       i_den,
    input  logic                            i_neg,
    output logic signed [m3i_pkg::Q_W-1:0]  o_q
);
    import m3i_pkg::*;
    logic [DIV_W-1:0] r_rem [DIV_W+1];
    logic [DIV_W-1:0] r_quo [DIV_W+1];
    logic [DIV_W-1:0] r_den [DIV_W+1];
    logic             r_neg [DIV_W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_quo[0] <= i_num;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
        end
    end

    for (genvar s = 0; s < DIV_W; s++) begin : g_stage
        logic [DIV_W:0] w_trial;
        logic [DIV_W:0] w_sub;
        assign w_trial = {r_rem[s], r_quo[s][DIV_W-1]};
        assign w_sub   = w_trial - {1'b0, r_den[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                if (!w_sub[DIV_W]) begin
                    r_rem[s+1] <= w_sub[DIV_W-1:0];
                    r_quo[s+1] <= {r_quo[s][DIV_W-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= w_trial[DIV_W-1:0];
                    r_quo[s+1] <= {r_quo[s][DIV_W-2:0], 1'b0};
                end
            end
        end
    end

    logic [Q_W-1:0] w_mag;
    assign w_mag = {1'b0, r_quo[DIV_W]};
    assign o_q = r_neg[DIV_W] ? -$signed(w_mag) : $signed(w_mag);
endmodule

[rtl/matrix3x3_inverse_top.sv]
// Channel | Direction | Payload
// i_in    | sink      | e00..e22, signed elements
// o_out   | source    | q00..q22, determinant, invertible
// One matrix is accepted per cycle unless the output stalls; depth is set by the nine
// bit-per-stage divider lanes (56 stages) plus six cofactor, determinant and entry stages.
// The whole pipeline advances only while the output stage can move, so a
// stall on the output holds every stage in place.
// Reset clears the valid bits of the pipeline; payload is not reset.
module matrix3x3_inverse_top #(
    parameter int ELEM_BITS = m3i_pkg::ELEM_BITS_DEF,
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    m3i_in_if.sink    i_in,
    m3i_out_if.source o_out
);
    import m3i_pkg::*;
    localparam int DEPTH = DIV_W + 6;

    logic w_en;
    logic [DEPTH-1:0] r_vld;
    assign w_en = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;
    assign o_out.valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[DEPTH-2:0], i_in.valid};
    end

    // Stage 1: element capture with sign extension from ELEM_BITS.
    logic signed [ELEM_W-1:0] w_e [9];
    logic signed [ELEM_W-1:0] r_m [9];
    assign w_e[0] = i_in.e00; assign w_e[1] = i_in.e01; assign w_e[2] = i_in.e02;
    assign w_e[3] = i_in.e10; assign w_e[4] = i_in.e11; assign w_e[5] = i_in.e12;
    assign w_e[6] = i_in.e20; assign w_e[7] = i_in.e21; assign w_e[8] = i_in.e22;
    for (genvar k = 0; k < 9; k++) begin : g_in
        always_ff @(posedge i_clk) begin
            if (w_en) r_m[k] <= ELEM_W'(signed'(w_e[k] <<< (ELEM_W - ELEM_BITS))
                                        >>> (ELEM_W - ELEM_BITS));
        end
    end

    // Stage 2: products of minors; stage 3: adjugate (signed minors).
    logic signed [PROD_W-1:0] r_pa [9];
    logic signed [PROD_W-1:0] r_pb [9];
    logic signed [ADJ_W-1:0]  r_adj [9];
    logic signed [ELEM_W-1:0] r_row0 [3];
    logic signed [ELEM_W-1:0] r_row0b [3];
    for (genvar i = 0; i < 3; i++) begin : g_ai
        for (genvar j = 0; j < 3; j++) begin : g_aj
            // adj[i][j] is the minor skipping row j, column i.
            localparam int R0 = (j == 0) ? 1 : 0;
            localparam int R1 = (j == 2) ? 1 : 2;
            localparam int C0 = (i == 0) ? 1 : 0;
            localparam int C1 = (i == 2) ? 1 : 2;
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_pa[i*3+j] <= PROD_W'(r_m[R0*3+C0] * r_m[R1*3+C1]);
                    r_pb[i*3+j] <= PROD_W'(r_m[R0*3+C1] * r_m[R1*3+C0]);
                    if (((i + j) % 2) == 1)
                        r_adj[i*3+j] <= ADJ_W'(r_pb[i*3+j] - r_pa[i*3+j]);
                    else
                        r_adj[i*3+j] <= ADJ_W'(r_pa[i*3+j] - r_pb[i*3+j]);
                end
            end
        end
    end
    for (genvar c = 0; c < 3; c++) begin : g_r0
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_row0[c]  <= r_m[c];
                r_row0b[c] <= r_row0[c];
            end
        end
    end

    // Stage 4: determinant terms from row 0 and adj column 0; stage 5: sum.
    logic signed [DET_W-1:0] r_dt [3];
    logic signed [DET_W-1:0] r_det;
    logic signed [ADJ_W-1:0] r_adj2 [9];
    logic signed [ADJ_W-1:0] r_adj3 [9];
    for (genvar c = 0; c < 3; c++) begin : g_dt
        always_ff @(posedge i_clk) begin
            if (w_en) r_dt[c] <= DET_W'(r_row0b[c] * r_adj[c*3]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_det  <= r_dt[0] + r_dt[1] + r_dt[2];
            r_adj2 <= r_adj;
            r_adj3 <= r_adj2;
        end
    end

    // Lanes: magnitude division, sign applied at the end.
    logic [DIV_W-1:0] w_dmag;
    logic             w_dneg;
    assign w_dneg = r_det[DET_W-1];
    assign w_dmag = DIV_W'(w_dneg ? -r_det : r_det);
    logic signed [Q_W-1:0] w_q [LANES];
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic signed [NUM_W-1:0] w_num;
        logic [NUM_W-1:0]        w_nmag;
        assign w_num  = NUM_W'(r_adj3[k]) <<< FRAC_BITS;
        assign w_nmag = w_num[NUM_W-1] ? NUM_W'(-w_num) : NUM_W'(w_num);
        m3i_div_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (DIV_W'(w_nmag)),
            .i_den (w_dmag),
            .i_neg (w_num[NUM_W-1] ^ w_dneg),
            .o_q   (w_q[k])
        );
    end

    // Determinant delay line to line up with the lane outputs, which pass through
    // the lane's entry register and then its quotient-bit stages.
    logic signed [DET_W-1:0] r_dpipe [DIV_W+1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dpipe[0] <= r_det;
            for (int s = 1; s <= DIV_W; s++) r_dpipe[s] <= r_dpipe[s-1];
        end
    end

    // Merge: zero determinant forces zero entries.
    logic w_inv;
    assign w_inv = (r_dpipe[DIV_W] != '0);
    assign o_out.determinant = r_dpipe[DIV_W];
    assign o_out.invertible  = w_inv;
    assign o_out.q00 = w_inv ? w_q[0] : '0;
    assign o_out.q01 = w_inv ? w_q[1] : '0;
    assign o_out.q02 = w_inv ? w_q[2] : '0;
    assign o_out.q10 = w_inv ? w_q[3] : '0;
    assign o_out.q11 = w_inv ? w_q[4] : '0;
    assign o_out.q12 = w_inv ? w_q[5] : '0;
    assign o_out.q20 = w_inv ? w_q[6] : '0;
    assign o_out.q21 = w_inv ? w_q[7] : '0;
    assign o_out.q22 = w_inv ? w_q[8] : '0;
endmodule

[test/matrix3x3_inverse_checker.sv]
`timescale 1ns / 1ps
module matrix3x3_inverse_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    m3i_in_if.sink   i_in,
    m3i_out_if.sink  i_out,
    output int       o_fail_count
);
    import m3i_pkg::*;

    typedef struct {
        logic signed [Q_W-1:0]   q [9];
        logic signed [DET_W-1:0] det;
        logic                    inv;
    } inverse_t;

    inverse_t pending_inverses[$];
    int       fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic inverse_t predict_inverse(input logic signed [ELEM_W-1:0] e [9]);
        longint   m [3][3];
        longint   v [4];
        longint   d, c, num;
        int       n;
        inverse_t r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = e[i*3+j];
        d = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                // Cofactor of element (j,i), placed at (i,j) of the adjugate.
                n = 0;
                for (int rr = 0; rr < 3; rr++)
                    for (int cc = 0; cc < 3; cc++)
                        if (rr != j && cc != i) begin
                            v[n] = m[rr][cc];
                            n++;
                        end
                c = v[0] * v[3] - v[1] * v[2];
                if ((i + j) % 2 == 1) c = -c;
                if (j == 0) d += m[0][i] * c;
                m[0][0] = m[0][0];
                r.q[i*3+j] = c;
            end
        for (int k = 0; k < 9; k++) begin
            num = longint'(r.q[k]) * (longint'(1) << 24);
            r.q[k] = (d != 0) ? Q_W'(num / d) : '0;
        end
        r.det = DET_W'(d);
        r.inv = (d != 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        logic signed [ELEM_W-1:0] e [9];
        inverse_t want;
        logic signed [Q_W-1:0] got [9];
        if (i_rst_n && i_in.valid && i_in.ready) begin
            e = '{i_in.e00, i_in.e01, i_in.e02, i_in.e10, i_in.e11, i_in.e12,
                  i_in.e20, i_in.e21, i_in.e22};
            pending_inverses.push_back(predict_inverse(e));
        end
        if (i_rst_n && i_out.valid && i_out.ready) begin
            if (pending_inverses.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                want = pending_inverses.pop_front();
                got = '{i_out.q00, i_out.q01, i_out.q02, i_out.q10, i_out.q11,
                        i_out.q12, i_out.q20, i_out.q21, i_out.q22};
                for (int k = 0; k < 9; k++)
                    if (got[k] !== want.q[k])
                        report_mismatch($sformatf("q%0d%0d", k / 3, k % 3),
                                        got[k], want.q[k]);
                if (i_out.determinant !== want.det)
                    report_mismatch("determinant", i_out.determinant, want.det);
                if (i_out.invertible !== want.inv)
                    report_mismatch("invertible", i_out.invertible, want.inv);
            end
        end
    end

    function automatic int outstanding();
        return pending_inverses.size();
    endfunction

    task automatic report_leftover();
        if (pending_inverses.size() != 0)
            report_mismatch("missing transactions", 0, pending_inverses.size());
    endtask
endmodule

[test/matrix3x3_inverse_top_test.sv]
`timescale 1ns / 1ps
module matrix3x3_inverse_top_test;
    import m3i_pkg::*;

    localparam int LATENCY = 62;
    localparam int STALL_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   accepted = 0;
    int   quiet_cycles = 0;
    bit   steady = 1'b0;
    bit   feeding = 1'b1;

    m3i_in_if  in_ch();
    m3i_out_if out_ch();

    matrix3x3_inverse_top DUT (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch));
    matrix3x3_inverse_checker checker_inst (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch),
                                            .i_out(out_ch), .o_fail_count(fail_count));

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        {in_ch.e00, in_ch.e01, in_ch.e02, in_ch.e10, in_ch.e11, in_ch.e12,
         in_ch.e20, in_ch.e21, in_ch.e22} = '0;
        out_ch.ready = 1'b0;
    end

    // The receiver stalls at random except during the steady stretch.
    always @(posedge i_clk)
        out_ch.ready <= steady || ($urandom_range(99) >= 29);

    // Watchdog on cycles in which no transaction happens on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && quiet_cycles > STALL_LIMIT && feeding) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [ELEM_W-1:0] random_element();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return ELEM_W'($urandom_range(6)) - 3;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic send_matrix(input logic [ELEM_W-1:0] e [9]);
        while (!steady && $urandom_range(99) < 29) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        {in_ch.e00, in_ch.e01, in_ch.e02, in_ch.e10, in_ch.e11, in_ch.e12,
         in_ch.e20, in_ch.e21, in_ch.e22} <= {e[0], e[1], e[2], e[3], e[4], e[5],
                                             e[6], e[7], e[8]};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        accepted++;
    endtask

    initial begin
        logic [ELEM_W-1:0] e [9];
        int waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: identity, scaled, singular, extremes, negative, permutation.
        send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
        send_matrix('{2, 0, 0, 0, 3, 0, 0, 0, 7});
        send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_matrix('{1, 2, 3, 4, 5, 6, 7, 8, 9});
        send_matrix('{16'h7fff, 0, 0, 0, 16'h7fff, 0, 0, 0, 16'h7fff});
        send_matrix('{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000});
        send_matrix('{16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
                      16'h7fff, 16'h7fff, 16'h8000});
        send_matrix('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                      16'hffff, 16'hffff, 16'hffff});
        send_matrix('{0, 1, 0, 0, 0, 1, 1, 0, 0});
        send_matrix('{-3, 1, 2, 5, -7, 1, 4, 4, -1});
        send_matrix('{16'h8000, 16'h7fff, 0, 16'h7fff, 16'h8000, 0, 0, 0, 1});
        send_matrix('{1, 16'h8000, 16'h8000, 0, 1, 16'h7fff, 0, 0, 1});
        for (int n = 0; n < 1800; n++) begin
            steady = (n >= 800 && n < 1000);
            for (int k = 0; k < 9; k++) e[k] = random_element();
            // Some rows repeated so that singular matrices keep turning up.
            if ($urandom_range(9) == 0)
                for (int k = 0; k < 3; k++) e[6+k] = e[k];
            send_matrix(e);
        end
        steady = 1'b0;
        in_ch.valid <= 1'b0;
        waited = 0;
        while (checker_inst.outstanding() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        feeding = 1'b0;
        checker_inst.report_leftover();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

[sim.f]
rtl/m3i_pkg.sv
rtl/m3i_if.sv
rtl/m3i_div_lane.sv
rtl/matrix3x3_inverse_top.sv
test/matrix3x3_inverse_checker.sv
test/matrix3x3_inverse_top_test.sv
